>>> rtl/core/edfs_pkg.sv
package edfs_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam int TIME_W   = 32;
  localparam int LEN_W    = 16;
  localparam int COUNT_W  = 4;
  localparam int SLOT_IN_W = 3;
  localparam int NUM_W    = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index as decoded from paddr above the byte offset.
  localparam logic [CFG_ADDR_W-3:0] REG_TASK_COUNT = '0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Static task description, written by load items.
  typedef struct packed {
    logic [LEN_W-1:0] period;
    logic [LEN_W-1:0] run;
  } task_cfg_t;

  // Per-slot dynamic scheduling state.
  typedef struct packed {
    logic [LEN_W-1:0]  remaining;
    logic [TIME_W-1:0] deadline;
    logic [LEN_W-1:0]  countdown;
  } task_dyn_t;

endpackage

>>> rtl/core/edf_periodic_task_scheduler_core.sv
// Earliest-deadline-first scheduler for periodic tasks. A load item (cmd 0) writes one slot's
// period and run length and gives no result. A tick item (cmd 1) walks the
// active slots in order through the per-slot state memory, one slot per cycle with a registered
// read, releasing due tasks and tracking the pending task with the earliest
// deadline; it then charges one unit of work to that task and delivers one result item with
// the tick time, idle flag and task number. A tick occupies the block through its scan, a
// final write-back state and an output state, its pace set by the single read port of
// the state memory. The result waits in an output register, so the next item is taken while
// it is stalled; a later tick holds its own result until that register is free.
// Per-slot state is zero after reset through valid bits; no clearing pass is needed.
module edf_periodic_task_scheduler_core #(
  parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [edfs_pkg::SLOT_IN_W-1:0]      in_task_slot,
  input  logic [edfs_pkg::LEN_W-1:0]          in_period_len,
  input  logic [edfs_pkg::LEN_W-1:0]          in_run_len,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [edfs_pkg::TIME_W-1:0]         out_tick_time,
  output logic                                out_idle,
  output logic [edfs_pkg::NUM_W-1:0]          out_task_number,

  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [edfs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [edfs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [edfs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SLOT_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int MAX_ACT = (TASK_SLOTS < 15) ? TASK_SLOTS : 15;
  localparam int CW      = edfs_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [CW-1:0]                    task_count_r, task_count_nxt;
  logic [CW-1:0]                    n_r, n_nxt;
  logic [CW-1:0]                    rd_cnt_r, rd_cnt_nxt;
  logic                             p1_vld_r, p1_vld_nxt;
  logic [SLOT_W-1:0]                p1_idx_r, p1_idx_nxt;
  logic                             best_found_r, best_found_nxt;
  logic [SLOT_W-1:0]                best_idx_r, best_idx_nxt;
  edfs_pkg::task_dyn_t              best_rec_r, best_rec_nxt;
  logic [edfs_pkg::TIME_W-1:0]      time_r, time_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [edfs_pkg::TIME_W-1:0]      out_time_r, out_time_nxt;
  logic                             out_idle_r, out_idle_nxt;
  logic [edfs_pkg::NUM_W-1:0]       out_num_r, out_num_nxt;

  logic                             in_acc;
  logic                             cfg_wr;
  logic                             cfg_sel_tc;
  logic [CW-1:0]                    n_eff;
  logic                             issue;
  logic [SLOT_W-1:0]                rd_addr;
  logic                             load_we;
  edfs_pkg::task_cfg_t              load_data;
  edfs_pkg::task_cfg_t              cfg_rd;
  edfs_pkg::task_dyn_t              st_rd;
  edfs_pkg::task_dyn_t              upd;
  logic                             take;
  logic                             st_we;
  logic [SLOT_W-1:0]                st_waddr;
  edfs_pkg::task_dyn_t              st_wdata;
  edfs_pkg::task_dyn_t              best_dec;
  logic                             out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign cfg_pready = 1'b1;
  assign cfg_sel_tc = (cfg_paddr[edfs_pkg::CFG_ADDR_W-1:2] == edfs_pkg::REG_TASK_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_tc;
  assign cfg_prdata = cfg_sel_tc ? edfs_pkg::CFG_DATA_W'(task_count_r) : '0;

  always_comb begin
    if (task_count_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(task_count_r) > MAX_ACT) begin
      n_eff = CW'(MAX_ACT);
    end else begin
      n_eff = task_count_r;
    end
  end

  assign load_we   = in_acc && (in_cmd == edfs_pkg::CMD_LOAD)
                     && (32'(in_task_slot) < TASK_SLOTS);
  assign load_data = '{period: in_period_len, run: in_run_len};

  assign issue   = (state_r == S_SCAN) && (rd_cnt_r < n_r);
  assign rd_addr = SLOT_W'(rd_cnt_r);

  edfs_cfg_mem #(.TASK_SLOTS(TASK_SLOTS)) u_cfg_mem (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (SLOT_W'(in_task_slot)),
    .wr_data (load_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (cfg_rd)
  );

  edfs_state_mem #(.TASK_SLOTS(TASK_SLOTS)) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (st_rd)
  );

  // Release update for the slot whose data has just come back from memory.
  always_comb begin
    upd = st_rd;
    if (st_rd.countdown == '0) begin
      upd.remaining = cfg_rd.run;
      upd.deadline  = time_r + edfs_pkg::TIME_W'(cfg_rd.period);
      upd.countdown = (cfg_rd.period == '0) ? '0 : cfg_rd.period - 1'b1;
    end else begin
      upd.countdown = st_rd.countdown - 1'b1;
    end
  end

  // Slots arrive in ascending order, so a strict compare keeps the lowest slot on a tie.
  assign take = p1_vld_r && (upd.remaining != '0)
                && (!best_found_r || (upd.deadline < best_rec_r.deadline));

  always_comb begin
    best_dec = best_rec_r;
    best_dec.remaining = best_rec_r.remaining - 1'b1;
  end

  // Scan writes back each slot in the cycle after its read; the final write charges the winner.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = p1_idx_r;
    st_wdata = upd;
    if ((state_r == S_SCAN) && p1_vld_r) begin
      st_we = 1'b1;
    end else if ((state_r == S_FIN) && best_found_r) begin
      st_we    = 1'b1;
      st_waddr = best_idx_r;
      st_wdata = best_dec;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    task_count_nxt = task_count_r;
    n_nxt          = n_r;
    rd_cnt_nxt     = rd_cnt_r;
    p1_vld_nxt     = issue;
    p1_idx_nxt     = issue ? rd_addr : p1_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_rec_nxt   = best_rec_r;
    time_nxt       = time_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_time_nxt   = out_time_r;
    out_idle_nxt   = out_idle_r;
    out_num_nxt    = out_num_r;

    if (cfg_wr) begin
      task_count_nxt = cfg_pwdata[CW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == edfs_pkg::CMD_TICK)) begin
          n_nxt          = n_eff;
          rd_cnt_nxt     = '0;
          best_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (take) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = p1_idx_r;
          best_rec_nxt   = upd;
        end
        if (!issue && p1_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = time_r;
          out_idle_nxt  = !best_found_r;
          out_num_nxt   = best_found_r ? edfs_pkg::NUM_W'(32'(best_idx_r) + 1) : '0;
          time_nxt      = time_r + 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= CW'(1);
      n_r          <= CW'(1);
      rd_cnt_r     <= '0;
      p1_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      n_r          <= n_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      p1_vld_r     <= p1_vld_nxt;
      best_found_r <= best_found_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r   <= p1_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_rec_r <= best_rec_nxt;
    out_time_r <= out_time_nxt;
    out_idle_r <= out_idle_nxt;
    out_num_r  <= out_num_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tick_time   = out_time_r;
  assign out_idle        = out_idle_r;
  assign out_task_number = out_num_r;

endmodule

>>> rtl/core/edfs_cfg_mem.sv
module edfs_cfg_mem #(
  parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF,
  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_addr,
  input  edfs_pkg::task_cfg_t wr_data,
  input  logic                rd_en,
  input  logic [SLOT_W-1:0]   rd_addr,
  output edfs_pkg::task_cfg_t rd_data
);

  edfs_pkg::task_cfg_t mem [TASK_SLOTS];
  edfs_pkg::task_cfg_t rd_data_r;

  // Entries that were never loaded are not defined and need no clearing.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/edfs_state_mem.sv
module edfs_state_mem #(
  parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF,
  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_addr,
  input  edfs_pkg::task_dyn_t wr_data,
  input  logic                rd_en,
  input  logic [SLOT_W-1:0]   rd_addr,
  output edfs_pkg::task_dyn_t rd_data
);

  edfs_pkg::task_dyn_t mem [TASK_SLOTS];
  edfs_pkg::task_dyn_t rd_q_r;
  logic [TASK_SLOTS-1:0] vld_r;
  logic [TASK_SLOTS-1:0] vld_nxt;
  logic                  rd_vld_r;
  logic                  rd_vld_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
    rd_vld_nxt = rd_vld_r;
    if (rd_en) begin
      rd_vld_nxt = vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // A slot not written since reset reads as all zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> test/edf_periodic_task_scheduler_core_tb.sv
module edf_periodic_task_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = edfs_pkg::TASK_SLOTS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 16;
  localparam int PHASE_ITEMS  = 235;

  typedef struct packed {
    logic                       cmd;
    logic [2:0]                 slot;
    logic [edfs_pkg::LEN_W-1:0] period;
    logic [edfs_pkg::LEN_W-1:0] run;
  } sched_item_t;

  typedef struct packed {
    logic [edfs_pkg::TIME_W-1:0] tick_time;
    logic                        idle;
    logic [edfs_pkg::NUM_W-1:0]  task_number;
  } sched_report_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [2:0]                 slot;
    logic [edfs_pkg::LEN_W-1:0] period;
    logic [edfs_pkg::LEN_W-1:0] run;
    logic [3:0]                 count;
    bit                         typed;
    sched_report_t              report;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_cmd;
  logic [edfs_pkg::SLOT_IN_W-1:0]  in_task_slot;
  logic [edfs_pkg::LEN_W-1:0]      in_period_len;
  logic [edfs_pkg::LEN_W-1:0]      in_run_len;
  logic                            out_valid;
  logic                            out_stall;
  logic [edfs_pkg::TIME_W-1:0]     out_tick_time;
  logic                            out_idle;
  logic [edfs_pkg::NUM_W-1:0]      out_task_number;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [edfs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [edfs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [edfs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the scheduler state, advanced once per accepted item.
  logic [edfs_pkg::LEN_W-1:0]  period_tab [SLOTS];
  logic [edfs_pkg::LEN_W-1:0]  run_tab [SLOTS];
  logic [edfs_pkg::LEN_W-1:0]  work_left [SLOTS];
  logic [edfs_pkg::TIME_W-1:0] deadline_tab [SLOTS];
  logic [edfs_pkg::LEN_W-1:0]  countdown_tab [SLOTS];
  logic [edfs_pkg::TIME_W-1:0] now_ticks;
  logic [3:0]                  slot_limit;

  sched_report_t tick_reports_q [$];
  dir_row_t      dir_rows [$];

  int in_idle_pct;
  int out_idle_pct;
  int mismatches;
  int reports_checked;
  int loads_sent;
  int ticks_sent;
  int cycle_cnt;

  edf_periodic_task_scheduler_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_task_slot    (in_task_slot),
    .in_period_len   (in_period_len),
    .in_run_len      (in_run_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tick_time   (out_tick_time),
    .out_idle        (out_idle),
    .out_task_number (out_task_number),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d reports outstanding.", cycle_cnt,
               tick_reports_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Loads only touch the tables; a tick releases due slots, runs one unit of the
  // pending slot with the earliest deadline, and reports it.
  task automatic schedule_step(input sched_item_t it, output bit has_report,
                               output sched_report_t rep);
    int used;
    int pick;
    has_report = 1'b0;
    rep = '0;
    if (it.cmd == edfs_pkg::CMD_LOAD) begin
      if (it.slot < SLOTS) begin
        period_tab[it.slot] = it.period;
        run_tab[it.slot]    = it.run;
      end
    end else begin
      used = (slot_limit == 4'd0) ? 1 : ((slot_limit > SLOTS) ? SLOTS : int'(slot_limit));
      for (int i = 0; i < used; i++) begin
        if (countdown_tab[i] == '0) begin
          work_left[i]     = run_tab[i];
          deadline_tab[i]  = now_ticks + edfs_pkg::TIME_W'(period_tab[i]);
          countdown_tab[i] = (period_tab[i] == '0) ? '0 : period_tab[i] - 1'b1;
        end else begin
          countdown_tab[i] = countdown_tab[i] - 1'b1;
        end
      end
      pick = -1;
      for (int i = 0; i < used; i++) begin
        if (work_left[i] != '0 && (pick < 0 || deadline_tab[i] < deadline_tab[pick]))
          pick = i;
      end
      rep.tick_time = now_ticks;
      if (pick >= 0) begin
        work_left[pick]  = work_left[pick] - 1'b1;
        rep.idle         = 1'b0;
        rep.task_number  = edfs_pkg::NUM_W'(pick + 1);
      end else begin
        rep.idle         = 1'b1;
        rep.task_number  = '0;
      end
      now_ticks  = now_ticks + 1'b1;
      has_report = 1'b1;
    end
  endtask

  function automatic sched_item_t random_item();
    sched_item_t it;
    int sel;
    it.slot   = 3'($urandom_range(0, 7));
    it.period = edfs_pkg::LEN_W'($urandom);
    it.run    = edfs_pkg::LEN_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 74) begin
      it.cmd = edfs_pkg::CMD_TICK;
    end else begin
      it.cmd = edfs_pkg::CMD_LOAD;
      // Mostly short periods so that slots keep releasing; long ones would
      // freeze a slot for the rest of the run.
      if (sel < 96) begin
        it.period = edfs_pkg::LEN_W'($urandom_range(0, 14));
        it.run    = edfs_pkg::LEN_W'($urandom_range(0, 6));
      end else if (sel < 99) begin
        it.period = edfs_pkg::LEN_W'($urandom_range(1, 14));
      end
    end
    return it;
  endfunction

  function automatic void add_row(row_kind_t kind, int slot, int period, int run, int count,
                                  bit typed, int t, bit idl, int num);
    dir_row_t r;
    r.kind   = kind;
    r.slot   = 3'(slot);
    r.period = edfs_pkg::LEN_W'(period);
    r.run    = edfs_pkg::LEN_W'(run);
    r.count  = 4'(count);
    r.typed  = typed;
    r.report = '{tick_time: edfs_pkg::TIME_W'(t), idle: idl,
                 task_number: edfs_pkg::NUM_W'(num)};
    dir_rows.push_back(r);
  endfunction

  // Called right after a falling edge; returns right after the falling edge that follows acceptance.
  task automatic send_item(input sched_item_t it, input bit use_typed,
                           input sched_report_t typed_rep);
    bit            has_rep;
    sched_report_t rep;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= it.cmd;
    in_task_slot  <= it.slot;
    in_period_len <= it.period;
    in_run_len    <= it.run;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_step(it, has_rep, rep);
    if (has_rep) tick_reports_q.push_back(use_typed ? typed_rep : rep);
    if (it.cmd == edfs_pkg::CMD_LOAD) loads_sent++;
    else ticks_sent++;
    @(negedge clk);
  endtask

  // Loads give no report, so a settle wait follows the last report before the block counts as idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tick_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_task_count(input logic [3:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {edfs_pkg::REG_TASK_COUNT, 2'b00};
    cfg_pwdata  <= edfs_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    slot_limit = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== edfs_pkg::CFG_DATA_W'(value)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("task_count readback: expected %0d, got %0h", value, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= rst_n && ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin : report_check
    sched_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected report: time %0d idle %0b task %0d", out_tick_time, out_idle,
                   out_task_number);
      end else begin
        want = tick_reports_q.pop_front();
        reports_checked++;
        if (out_tick_time !== want.tick_time || out_idle !== want.idle ||
            out_task_number !== want.task_number) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Report %0d: expected time %0d idle %0b task %0d, got %0d %0b %0d",
                     reports_checked, want.tick_time, want.idle, want.task_number,
                     out_tick_time, out_idle, out_task_number);
        end
      end
    end
  end

  initial begin
    logic [3:0] phase_counts [6];
    sched_item_t it;

    phase_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd11};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = edfs_pkg::CMD_LOAD;
    in_task_slot  = '0;
    in_period_len = '0;
    in_run_len    = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_idle_pct   = 0;
    out_idle_pct  = 0;
    mismatches    = 0;
    reports_checked = 0;
    loads_sent    = 0;
    ticks_sent    = 0;
    cycle_cnt     = 0;
    now_ticks     = '0;
    slot_limit    = 4'd1;
    for (int i = 0; i < SLOTS; i++) begin
      period_tab[i]    = '0;
      run_tab[i]       = '0;
      work_left[i]     = '0;
      deadline_tab[i]  = '0;
      countdown_tab[i] = '0;
    end

    // One slot active after reset: run two units, then idle until the reload.
    add_row(ROW_LOAD, 0, 4, 2, 0, 0, 0, 0, 0);
    add_row(ROW_TICK, 7, 16'hFFFF, 16'hFFFF, 0, 1, 0, 0, 1);
    add_row(ROW_TICK, 0, 0, 0, 0, 1, 1, 0, 1);
    add_row(ROW_TICK, 3, 0, 0, 0, 1, 2, 1, 0);
    // A load mid-run changes nothing until the slot's next release.
    add_row(ROW_LOAD, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0, 0, 1, 3, 1, 0);
    add_row(ROW_TICK, 5, 0, 0, 0, 1, 4, 0, 1);
    add_row(ROW_LOAD, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 2, 3, 3, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 3, 3, 3, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 4, 1, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 5, 16'h8000, 16'h0001, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 6, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 7, 5, 1, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, 0, 0, 8, 0, 0, 0, 0);
    for (int k = 0; k < 5; k++) add_row(ROW_TICK, k, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 2; k++) add_row(ROW_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, 0, 0, 15, 0, 0, 0, 0);
    for (int k = 0; k < 3; k++) add_row(ROW_TICK, 6, 0, 0, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_task_count(dir_rows[r].count);
      end else begin
        it.cmd    = (dir_rows[r].kind == ROW_TICK) ? edfs_pkg::CMD_TICK : edfs_pkg::CMD_LOAD;
        it.slot   = dir_rows[r].slot;
        it.period = dir_rows[r].period;
        it.run    = dir_rows[r].run;
        send_item(it, dir_rows[r].typed, dir_rows[r].report);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_task_count(phase_counts[ph]);
      case (ph / 2)
        0: begin
          in_idle_pct  = 11;
          out_idle_pct = 78;
        end
        1: begin
          in_idle_pct  = 78;
          out_idle_pct = 11;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, '0);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (tick_reports_q.size() != 0) mismatches += tick_reports_q.size();
    $display("Sent %0d loads and %0d ticks; %0d schedule reports compared, %0d mismatches.",
             loads_sent, ticks_sent, reports_checked, mismatches);
    $display("Task counts 0, 1, 5, 8, 11 and 15 were applied under three stall patterns.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/edfs_pkg.sv
rtl/core/edfs_cfg_mem.sv
rtl/core/edfs_state_mem.sv
rtl/core/edf_periodic_task_scheduler_core.sv
test/edf_periodic_task_scheduler_core_tb.sv
